### src/cma_pkg.sv
`default_nettype none

package cma_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CSR_W    = 4;
   localparam logic [CSR_W-1:0] HALF_RESET = 4'd5;

   // controller -> datapath
   typedef struct packed {
      logic load;        // shift in the accepted sample
      logic plan;        // set up the output schedule for this sample
      logic start;       // open one output window
      logic acc;         // add one shift-line entry
      logic div_start;   // load the divider
      logic div_step;    // one quotient bit
      logic emit;        // load the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic emit_any;    // this sample produces at least one output
      logic acc_done;    // the entry being added is the last of the window
      logic div_done;    // the current step is the last quotient bit
      logic out_free;    // result register can take a value this cycle
      logic more;        // flush still has positions pending
   } status_type;

endpackage

`default_nettype wire

### src/cma_if.sv
`default_nettype none

interface cma_req_if;
   import cma_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface cma_rsp_if;
   import cma_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] filtered;
   logic                       final_res;

   modport source (output valid, output filtered, output final_res, input ready);
   modport sink   (input valid, input filtered, input final_res, output ready);
endinterface

`default_nettype wire

### src/cma_ctrl.sv
`default_nettype none

module cma_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  cma_pkg::status_type  status,
   output cma_pkg::cmd_type     cmd
);
   import cma_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      PLAN,
      START,
      ACC,
      DIV_INIT,
      DIV,
      EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = PLAN;
            end
         end
         PLAN: begin
            cmd.plan = 1'b1;
            state_in = status.emit_any ? START : IDLE;
         end
         START: begin
            cmd.start = 1'b1;
            state_in  = ACC;
         end
         ACC: begin
            cmd.acc = 1'b1;
            if (status.acc_done) begin
               state_in = DIV_INIT;
            end
         end
         DIV_INIT: begin
            cmd.div_start = 1'b1;
            state_in      = DIV;
         end
         DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = EMIT;
            end
         end
         EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.more ? START : IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // no new transfer is taken while an item is still being worked on
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == IDLE))
      else $error("ready outside idle");

   a_emit_after_div: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && status.div_done) |=> (state_ff == EMIT))
      else $error("division end did not lead to emit");

   a_acc_after_start: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> cmd.acc)
      else $error("window opened without accumulation");

endmodule

`default_nettype wire

### src/cma_datapath.sv
`default_nettype none

module cma_datapath #(
   parameter int MAX_HALF = 15
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  cma_pkg::cmd_type                      cmd,
   output cma_pkg::status_type                   status,
   input  wire                                   csr_we,
   input  wire        [cma_pkg::CSR_W-1:0]       csr_wdata,
   input  wire signed [cma_pkg::SAMPLE_W-1:0]    req_sample,
   input  wire                                   req_last,
   input  wire                                   rsp_ready,
   output logic                                  rsp_valid,
   output logic signed [cma_pkg::SAMPLE_W-1:0]   rsp_filtered,
   output logic                                  rsp_final
);
   import cma_pkg::*;

   localparam int DEPTH  = 2 * MAX_HALF + 1;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = SAMPLE_W + IDX_W;
   localparam int STEP_W = $clog2(SUM_W);
   localparam int WC_W   = (IDX_W > CSR_W) ? IDX_W : CSR_W;

   // shift line, entry 0 newest
   logic signed [SAMPLE_W-1:0] line_ff [DEPTH];
   logic [CNT_W-1:0]           seen_ff;
   logic [CSR_W-1:0]           half_ff;
   logic                       last_ff;
   logic [IDX_W-1:0]           d_ff;
   logic [IDX_W-1:0]           lim_ff;
   logic [IDX_W-1:0]           k_ff;
   logic signed [SUM_W-1:0]    acc_ff;
   logic [SUM_W-1:0]           quo_ff;
   logic [CNT_W-1:0]           rem_ff;
   logic [CNT_W-1:0]           dvs_ff;
   logic [STEP_W-1:0]          step_ff;
   logic                       neg_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;
   logic                       rsp_final_ff;

   logic [CNT_W-1:0]           seen_m1;
   logic [IDX_W-1:0]           newest;
   logic [WC_W-1:0]            half_ext;
   logic [WC_W-1:0]            w_cl;
   logic [IDX_W-1:0]           w;
   logic [IDX_W-1:0]           top;
   logic [IDX_W-1:0]           lim_sum;
   logic [IDX_W-1:0]           lim_calc;
   logic [SUM_W-1:0]           acc_mag;
   logic [CNT_W:0]             rem_sh;
   logic [CNT_W:0]             rem_sub;
   logic                       q_bit;
   logic [SAMPLE_W-1:0]        q_mag;
   logic signed [SAMPLE_W-1:0] q_res;
   logic                       is_final;

   always_comb begin
      seen_m1  = seen_ff - CNT_W'(1);
      newest   = seen_m1[IDX_W-1:0];
      half_ext = WC_W'(half_ff);
      w_cl     = (half_ext > WC_W'(MAX_HALF)) ? WC_W'(MAX_HALF) : half_ext;
      w        = w_cl[IDX_W-1:0];
      top      = (w < newest) ? w : newest;
      // in a flush the window ends at entry d+w, otherwise at entry 2w; both are clipped at the newest
      lim_sum  = last_ff ? (d_ff + w) : (w + w);
      lim_calc = (lim_sum > newest) ? newest : lim_sum;

      acc_mag  = acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : SUM_W'(acc_ff);

      rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
      q_bit    = (rem_sh >= {1'b0, dvs_ff});
      rem_sub  = q_bit ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;

      // magnitude never exceeds 2^15, so the low bits carry it
      q_mag    = quo_ff[SAMPLE_W-1:0];
      q_res    = neg_ff ? -$signed(q_mag) : $signed(q_mag);
      is_final = last_ff && (d_ff == '0);
   end

   always_comb begin
      status.emit_any = last_ff || (newest >= w);
      status.acc_done = (k_ff == lim_ff);
      status.div_done = (step_ff == STEP_W'(SUM_W - 1));
      status.out_free = !rsp_valid_ff || rsp_ready;
      status.more     = last_ff && (d_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         line_ff[0] <= req_sample;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         half_ff      <= HALF_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            half_ff <= csr_wdata;
         end
         if (cmd.load && (seen_ff != CNT_W'(DEPTH))) begin
            seen_ff <= seen_ff + CNT_W'(1);
         end else if (cmd.emit && is_final) begin
            seen_ff <= '0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         last_ff <= req_last;
      end
      if (cmd.plan) begin
         d_ff <= top;
      end else if (cmd.emit && status.more) begin
         d_ff <= d_ff - IDX_W'(1);
      end
      if (cmd.start) begin
         lim_ff <= lim_calc;
         k_ff   <= '0;
         acc_ff <= '0;
      end else if (cmd.acc) begin
         acc_ff <= acc_ff + {{IDX_W{line_ff[k_ff][SAMPLE_W-1]}}, line_ff[k_ff]};
         k_ff   <= k_ff + IDX_W'(1);
      end
      if (cmd.div_start) begin
         quo_ff  <= acc_mag;
         rem_ff  <= '0;
         dvs_ff  <= CNT_W'(lim_ff) + CNT_W'(1);
         neg_ff  <= acc_ff[SUM_W-1];
         step_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= {quo_ff[SUM_W-2:0], q_bit};
         rem_ff  <= rem_sub[CNT_W-1:0];
         step_ff <= step_ff + STEP_W'(1);
      end
      if (cmd.emit) begin
         rsp_data_ff  <= q_res;
         rsp_final_ff <= is_final;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_data_ff;
   assign rsp_final    = rsp_final_ff;

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNT_W'(DEPTH))
      else $error("seen count above line depth");

   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result register overwritten");

   a_acc_in_window: assert property (@(posedge clock) disable iff (reset)
      cmd.acc |-> (k_ff <= lim_ff))
      else $error("accumulation ran past the window");

   a_final_clears_stream: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && is_final) |=> (seen_ff == '0) && rsp_valid_ff && rsp_final_ff)
      else $error("final output did not end the stream");

endmodule

`default_nettype wire

### src/centered_moving_average_top.sv
`default_nettype none
// Each output takes one add per averaged sample (L+1 of them) and a restoring
// divider giving one quotient bit a cycle over W = 16 + clog2(2*MAX_HALF+1) bits
// (21 at the default), and then waits for rsp ready while the result register is
// full. A new sample is accepted only once every output of the previous one is in
// the result register; a flagged sample emits up to window_half+1 outputs.
// Reset (synchronous, active high) clears the stream state, sets window_half to 5.

module centered_moving_average_top #(
   parameter int MAX_HALF = 15
) (
   input  wire                          clock,
   input  wire                          reset,
   cma_req_if.sink                      req_ch,
   cma_rsp_if.source                    rsp_ch,
   input  wire                          csr_we,
   input  wire [cma_pkg::CSR_W-1:0]     csr_wdata
);
   import cma_pkg::*;

   cmd_type    cmd;
   status_type status;

   cma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cma_datapath #(
      .MAX_HALF (MAX_HALF)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_sample   (req_ch.sample),
      .req_last     (req_ch.last_sample),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_filtered (rsp_ch.filtered),
      .rsp_final    (rsp_ch.final_res)
   );

endmodule

`default_nettype wire

### verif/tb.sv
`default_nettype none

typedef struct packed {
   logic signed [15:0] filtered;
   logic               final_res;
} mean_item_t;

// Tracks the filter state and queues the averages the block should produce.
class mean_tracker #(int MAX_HALF = 15);
   localparam int LINE_DEPTH = 2 * MAX_HALF + 1;

   logic [3:0]         half;
   logic signed [15:0] line [LINE_DEPTH];
   int                 seen;
   mean_item_t         expected_means[$];
   int                 errors;

   function new();
      half = cma_pkg::HALF_RESET;
      seen = 0;
      errors = 0;
      foreach (line[k]) line[k] = '0;
   endfunction

   function void set_half(logic [3:0] v);
      half = v;
   endfunction

   function int pending();
      return expected_means.size();
   endfunction

   // Mean of line entries 0..top, truncated toward zero.
   function logic signed [15:0] window_mean(int top);
      int acc;
      acc = 0;
      for (int k = 0; k <= top; k++) acc += line[k];
      return 16'(acc / (top + 1));
   endfunction

   function void note(logic signed [15:0] s, logic lst);
      int         w;
      int         newest;
      int         lim;
      int         top;
      mean_item_t m;
      for (int k = LINE_DEPTH - 1; k > 0; k--) line[k] = line[k-1];
      line[0] = s;
      if (seen < LINE_DEPTH) seen++;
      newest = seen - 1;
      w = (int'(half) > MAX_HALF) ? MAX_HALF : int'(half);
      if (!lst) begin
         if (newest >= w) begin
            lim = (2 * w > newest) ? newest : 2 * w;
            m.filtered = window_mean(lim);
            m.final_res = 1'b0;
            expected_means.push_back(m);
         end
      end else begin
         // flush every pending position, oldest first
         top = (w < newest) ? w : newest;
         for (int d = top; d >= 0; d--) begin
            lim = (d + w > newest) ? newest : d + w;
            m.filtered = window_mean(lim);
            m.final_res = (d == 0);
            expected_means.push_back(m);
         end
         seen = 0;
      end
   endfunction

   task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
   endtask

   task check(logic signed [15:0] f, logic fin);
      mean_item_t m;
      if (expected_means.size() == 0) begin
         report($sformatf("unexpected result filtered=%0d final=%0b", f, fin));
         return;
      end
      m = expected_means.pop_front();
      if (f !== m.filtered)
         report($sformatf("filtered got %0d want %0d", f, m.filtered));
      if (fin !== m.final_res)
         report($sformatf("final_res got %0b want %0b (filtered %0d)", fin, m.final_res,
                          m.filtered));
   endtask
endclass

module tb;
   import cma_pkg::*;

   localparam int MAX_HALF      = 15;
   localparam int ITEMS         = 350;
   localparam int SETTLE_CYCLES = 64;
   localparam int STALL_LIMIT   = 3000;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [3:0] csr_wdata;
   logic       steady;
   int         items_sent;

   mean_tracker #(MAX_HALF) means;

   cma_req_if req_if ();
   cma_rsp_if rsp_if ();

   centered_moving_average_top #(.MAX_HALF(MAX_HALF)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'($urandom_range(31)) - 16'sd16;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [3:0] pick_half();
      case ($urandom_range(5))
         0: return 4'd0;
         1: return 4'd15;
         default: return 4'($urandom_range(15));
      endcase
   endfunction

   task automatic send_sample(input logic signed [15:0] s, input logic lst);
      while (!steady && $urandom_range(99) < 9) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.sample      <= s;
      req_if.last_sample <= lst;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
   endtask

   // Hold off the sender until every queued average has come back.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (means.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_half(input logic [3:0] v);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      means.set_half(v);
   endtask

   // mid < 0: no window change inside the stream
   task automatic send_stream(input int len, input int mid);
      for (int i = 0; i < len; i++) begin
         if (i == mid) write_half(pick_half());
         send_sample(rand_sample(), i == len - 1);
      end
   endtask

   // result side: random back-pressure, checks every transfer
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            means.check(rsp_if.filtered, rsp_if.final_res);
         rsp_if.ready <= steady || ($urandom_range(99) >= 9);
      end
   end

   // input monitor and stall watchdog
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset) begin
            quiet_cycles = 0;
         end else if (req_if.valid && req_if.ready) begin
            means.note(req_if.sample, req_if.last_sample);
            quiet_cycles = 0;
         end else if (rsp_if.valid && rsp_if.ready) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("TIMEOUT: no transfer for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int len;
      int mid;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_wdata          <= '0;
      req_if.valid       <= 1'b0;
      req_if.sample      <= '0;
      req_if.last_sample <= 1'b0;
      steady     = 1'b0;
      items_sent = 0;
      means      = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset window: single-sample stream, then a stream shorter than the window
      send_sample(16'sh7fff, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'shffff, 1'b1);

      write_half(4'd0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b1);

      write_half(4'd15);
      for (int i = 0; i < 6; i++)
         send_sample(i[0] ? 16'sh8000 : 16'sh7fff, i == 5);
      send_sample(16'sh0001, 1'b1);

      // window changed in the middle of a stream
      write_half(4'd2);
      for (int i = 0; i < 4; i++) send_sample(16'(100 * i - 200), 1'b0);
      write_half(4'd7);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh1234, 1'b1);

      while (items_sent < ITEMS) begin
         if ($urandom_range(3) == 0) write_half(pick_half());
         steady = (items_sent >= 150) && (items_sent < 230);
         case ($urandom_range(9))
            0: len = $urandom_range(70, 40);   // saturates the sample count
            1: len = 1;
            default: len = $urandom_range(16, 2);
         endcase
         mid = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : -1;
         send_stream(len, mid);
      end
      steady = 1'b0;

      wait_drained();
      repeat (200) @(posedge clock);
      if (means.pending() != 0)
         means.report($sformatf("%0d averages never arrived", means.pending()));
      if (means.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
